@@ rtl/core/trpb_pkg.sv @@
package trpb_pkg;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned GUARD_US  = 1000;
  localparam int unsigned ID_BITS   = 31;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned DELAY_BITS  = 16;
  localparam int unsigned WAIT_BITS   = 32;

  localparam logic [1:0] FUNC_ARRIVE = 2'd0;
  localparam logic [1:0] FUNC_POLL   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_POLL,
    OP_FLUSH,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic recovered;
  } cmd_t;

  function automatic op_e classify(input logic [1:0] func);
    op_e op;
    unique case (func)
      FUNC_ARRIVE: op = OP_ARRIVE;
      FUNC_POLL:   op = OP_POLL;
      FUNC_FLUSH:  op = OP_FLUSH;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/core/trpb_div.sv @@
module trpb_div #(
  parameter int unsigned WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             busy_o,
  output logic [WIDTH-1:0] quot_o
);

  // x / 1000 = (x >> 3) / 125, taken 16 bits per cycle by reciprocal multiplication
  localparam int unsigned SW  = WIDTH - 3;
  localparam int unsigned NCH = (SW + 15) / 16;
  localparam int unsigned PW  = NCH * 16;
  localparam int unsigned CW  = $clog2(NCH + 1);
  localparam logic [22:0] DIGIT_DIV = 23'd125;
  localparam logic [23:0] RECIP     = 24'd8589935;  // ceil(2^30 / 125)

  logic [CW-1:0] cnt_q;
  logic [PW-1:0] num_q, quot_q;
  logic [6:0]    rem_q, rem_d;
  logic [22:0]   part;
  logic [46:0]   prod;
  logic [15:0]   digit;

  // remainder below 125 keeps part under 2^23, exact for that range
  always_comb begin
    part  = {rem_q, num_q[PW-1 -: 16]};
    prod  = 47'(part) * 47'(RECIP);
    digit = prod[45:30];
    rem_d = 7'(part - 23'(digit) * DIGIT_DIV);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= CW'(NCH);
      num_q  <= PW'(dividend_i >> 3);
      quot_q <= '0;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      num_q  <= num_q << 16;
      quot_q <= {quot_q[PW-17:0], digit};
      rem_q  <= rem_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = WIDTH'(quot_q);

endmodule

@@ rtl/core/trpb_front.sv @@
module trpb_front import trpb_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [ID_BITS-1:0]     packet_id_i,
  input  logic [HANDLE_BITS-1:0] packet_handle_i,
  input  logic [TIME_BITS-1:0]   sent_time_us_i,
  input  logic [TIME_BITS-1:0]   now_us_i,
  input  logic                   recovered_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_pop_i,
  output cmd_t                   cmd_o,
  output logic [ID_BITS-1:0]     cmd_id_o,
  output logic [HANDLE_BITS-1:0] cmd_handle_o,
  output logic [TIME_BITS-1:0]   cmd_sent_o,
  output logic [TIME_BITS-1:0]   cmd_now_o
);

  // two-entry item queue
  cmd_t                   q_cmd    [2];
  logic [ID_BITS-1:0]     q_id     [2];
  logic [HANDLE_BITS-1:0] q_handle [2];
  logic [TIME_BITS-1:0]   q_sent   [2];
  logic [TIME_BITS-1:0]   q_now    [2];

  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_stall_o  = count_q == 2'd2;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = count_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd[wr_ptr_q]    <= '{op: classify(func_i), recovered: recovered_i};
      q_id[wr_ptr_q]     <= packet_id_i;
      q_handle[wr_ptr_q] <= packet_handle_i;
      q_sent[wr_ptr_q]   <= sent_time_us_i;
      q_now[wr_ptr_q]    <= now_us_i;
    end
  end

  assign cmd_o        = q_cmd[rd_ptr_q];
  assign cmd_id_o     = q_id[rd_ptr_q];
  assign cmd_handle_o = q_handle[rd_ptr_q];
  assign cmd_sent_o   = q_sent[rd_ptr_q];
  assign cmd_now_o    = q_now[rd_ptr_q];

endmodule

@@ rtl/core/trpb_back.sv @@
module trpb_back import trpb_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [DELAY_BITS-1:0]  delay_ms_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  cmd_t                   cmd_i,
  input  logic [ID_BITS-1:0]     cmd_id_i,
  input  logic [HANDLE_BITS-1:0] cmd_handle_i,
  input  logic [TIME_BITS-1:0]   cmd_sent_i,
  input  logic [TIME_BITS-1:0]   cmd_now_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   released_o,
  output logic [ID_BITS-1:0]     out_id_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   pending_o,
  output logic [WAIT_BITS-1:0]   wait_ms_o,
  output logic                   dropped_o,
  output logic                   last_o
);

  localparam int unsigned IDX = $clog2(RING_DEPTH);
  localparam int unsigned WK  = $clog2(RING_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_WIN_CHK,
    ST_DUE_MUL,
    ST_DUE_SENT,
    ST_DUE_REF,
    ST_DUE_LOC,
    ST_WRITE,
    ST_PASS_INIT,
    ST_PASS_RD,
    ST_PASS_CHK,
    ST_STAT_RD,
    ST_STAT_CHK,
    ST_STAT_DIV,
    ST_EMIT
  } state_e;

  state_e state_q;

  cmd_t                   cmd_q;
  logic [ID_BITS-1:0]     id_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [TIME_BITS-1:0]   sent_q, now_q;

  logic                   started_q;
  logic [TIME_BITS-1:0]   local_ref_q, sender_ref_q;
  logic [ID_BITS:0]       next_q;
  logic [IDX-1:0]         next_slot_q;
  logic [ID_BITS-1:0]     highest_q;
  logic [RING_DEPTH-1:0]  slot_full_q;

  logic [TIME_BITS-1:0]   due_q, thr_q;
  logic [ID_BITS:0]       span_q;
  logic [WK-1:0]          walked_q;
  logic                   dropped_q, pending_q;
  logic [WAIT_BITS-1:0]   wait_q;

  logic                   held_v_q;
  logic [ID_BITS-1:0]     held_id_q;
  logic [HANDLE_BITS-1:0] held_handle_q;

  logic                   out_valid_q, out_released_q, out_pending_q, out_dropped_q, out_last_q;
  logic [ID_BITS-1:0]     out_id_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [WAIT_BITS-1:0]   out_wait_q;

  // slot store, read every cycle at the release pointer's slot
  logic [TIME_BITS-1:0]   due_mem    [RING_DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [RING_DEPTH];
  logic [TIME_BITS-1:0]   due_rd_q;
  logic [HANDLE_BITS-1:0] handle_rd_q;
  logic                   mem_we;

  logic [IDX-1:0]         pid_slot;
  logic                   ms_start, ms_busy;
  logic [TIME_BITS-1:0]   ms_quot;

  logic                   out_free, ready_pending, cur_full;
  logic                   emit_mid, emit_last;
  logic [TIME_BITS-1:0]   due_eff;
  logic [TIME_BITS:0]     thr_sum;
  logic [ID_BITS:0]       win_lo, win_hi;
  logic [IDX-1:0]         next_slot_inc;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign ready_pending = next_q <= {1'b0, highest_q};
  assign cur_full      = slot_full_q[next_slot_q];
  assign due_eff       = cur_full ? due_rd_q : '0;
  assign thr_sum       = {1'b0, now_q} + (TIME_BITS+1)'(GUARD_US);
  assign next_slot_inc = (next_slot_q == IDX'(RING_DEPTH - 1)) ? '0 : next_slot_q + 1'b1;
  assign win_lo        = (next_q < {1'b0, id_q}) ? next_q : {1'b0, id_q};
  assign win_hi        = (highest_q > id_q) ? {1'b0, highest_q} : {1'b0, id_q};

  // ring depth is a power of two, the slot is the low id bits
  assign pid_slot = id_q[IDX-1:0];

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign ms_start   = (state_q == ST_STAT_CHK) && ready_pending && (due_eff > now_q);
  assign mem_we     = state_q == ST_WRITE;
  assign emit_mid   = (state_q == ST_PASS_CHK) && !(due_eff > thr_q) && cur_full
                      && held_v_q && out_free;
  assign emit_last  = (state_q == ST_EMIT) && out_free;

  trpb_div #(.WIDTH(TIME_BITS)) u_ms_div (
    .clk_i,
    .rst_ni,
    .start_i    (ms_start),
    .dividend_i (due_eff - now_q),
    .busy_o     (ms_busy),
    .quot_o     (ms_quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      due_mem[pid_slot]    <= due_q;
      handle_mem[pid_slot] <= handle_q;
    end
    due_rd_q    <= due_mem[next_slot_q];
    handle_rd_q <= handle_mem[next_slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= '{op: OP_NOP, recovered: 1'b0};
      id_q           <= '0;
      handle_q       <= '0;
      sent_q         <= '0;
      now_q          <= '0;
      started_q      <= 1'b0;
      local_ref_q    <= '0;
      sender_ref_q   <= '0;
      next_q         <= '0;
      next_slot_q    <= '0;
      highest_q      <= '0;
      slot_full_q    <= '0;
      due_q          <= '0;
      thr_q          <= '0;
      span_q         <= '0;
      walked_q       <= '0;
      dropped_q      <= 1'b0;
      pending_q      <= 1'b0;
      wait_q         <= '0;
      held_v_q       <= 1'b0;
      held_id_q      <= '0;
      held_handle_q  <= '0;
      out_valid_q    <= 1'b0;
      out_released_q <= 1'b0;
      out_id_q       <= '0;
      out_handle_q   <= '0;
      out_pending_q  <= 1'b0;
      out_wait_q     <= '0;
      out_dropped_q  <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      out_valid_q <= emit_mid || emit_last || (out_valid_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q     <= cmd_i;
            id_q      <= cmd_id_i;
            handle_q  <= cmd_handle_i;
            sent_q    <= cmd_sent_i;
            now_q     <= cmd_now_i;
            dropped_q <= 1'b0;
            held_v_q  <= 1'b0;
            unique case (cmd_i.op)
              OP_ARRIVE: begin
                if (!started_q) begin
                  started_q    <= 1'b1;
                  local_ref_q  <= cmd_now_i;
                  sender_ref_q <= cmd_sent_i;
                  next_q       <= {1'b0, cmd_id_i};
                  highest_q    <= cmd_id_i;
                  state_q      <= ST_DUE_MUL;
                end else begin
                  state_q <= ST_WIN;
                end
              end
              OP_POLL: state_q <= ST_PASS_INIT;
              OP_FLUSH: begin
                started_q    <= 1'b0;
                local_ref_q  <= '0;
                sender_ref_q <= '0;
                next_q       <= '0;
                next_slot_q  <= '0;
                highest_q    <= '0;
                slot_full_q  <= '0;
                state_q      <= ST_STAT_RD;
              end
              default: state_q <= ST_STAT_RD;
            endcase
          end
        end
        ST_WIN: begin
          span_q  <= win_hi - win_lo;
          state_q <= ST_WIN_CHK;
        end
        ST_WIN_CHK: begin
          if (span_q < (ID_BITS+1)'(RING_DEPTH)) begin
            state_q <= ST_DUE_MUL;
          end else begin
            dropped_q <= 1'b1;
            state_q   <= ST_STAT_RD;
          end
        end
        ST_DUE_MUL: begin
          due_q   <= TIME_BITS'(32'(delay_ms_i) * 32'(US_PER_MS));
          state_q <= ST_DUE_SENT;
        end
        ST_DUE_SENT: begin
          due_q   <= due_q + sent_q;
          state_q <= ST_DUE_REF;
        end
        ST_DUE_REF: begin
          due_q   <= due_q - sender_ref_q;
          state_q <= ST_DUE_LOC;
        end
        ST_DUE_LOC: begin
          // recovered packets are due at once
          due_q   <= cmd_q.recovered ? '0 : due_q + local_ref_q;
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          slot_full_q[pid_slot] <= 1'b1;
          if (id_q > highest_q) begin
            highest_q <= id_q;
          end
          if ({1'b0, id_q} <= next_q) begin
            next_q      <= {1'b0, id_q};
            next_slot_q <= pid_slot;
            state_q     <= ST_PASS_INIT;
          end else begin
            state_q <= ST_STAT_RD;
          end
        end
        ST_PASS_INIT: begin
          thr_q    <= thr_sum[TIME_BITS] ? '1 : thr_sum[TIME_BITS-1:0];
          walked_q <= '0;
          state_q  <= ST_PASS_RD;
        end
        ST_PASS_RD: begin
          if (ready_pending && (walked_q < WK'(RING_DEPTH))) begin
            state_q <= ST_PASS_CHK;
          end else begin
            state_q <= ST_STAT_RD;
          end
        end
        ST_PASS_CHK: begin
          if (due_eff > thr_q) begin
            state_q <= ST_STAT_RD;
          end else if (!cur_full || !held_v_q || out_free) begin
            if (cur_full) begin
              // the previous release is not the last one, send it on
              if (held_v_q) begin
                out_released_q <= 1'b1;
                out_id_q       <= held_id_q;
                out_handle_q   <= held_handle_q;
                out_pending_q  <= 1'b0;
                out_wait_q     <= '0;
                out_dropped_q  <= 1'b0;
                out_last_q     <= 1'b0;
              end
              held_v_q                 <= 1'b1;
              held_id_q                <= next_q[ID_BITS-1:0];
              held_handle_q            <= handle_rd_q;
              slot_full_q[next_slot_q] <= 1'b0;
            end
            next_q      <= next_q + 1'b1;
            next_slot_q <= next_slot_inc;
            walked_q    <= walked_q + 1'b1;
            state_q     <= ST_PASS_RD;
          end
        end
        ST_STAT_RD: state_q <= ST_STAT_CHK;
        ST_STAT_CHK: begin
          pending_q <= ready_pending;
          wait_q    <= '0;
          state_q   <= ms_start ? ST_STAT_DIV : ST_EMIT;
        end
        ST_STAT_DIV: begin
          if (!ms_busy) begin
            wait_q  <= ((ms_quot >> WAIT_BITS) != '0) ? '1 : ms_quot[WAIT_BITS-1:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_released_q <= held_v_q;
            out_id_q       <= held_v_q ? held_id_q : '0;
            out_handle_q   <= held_v_q ? held_handle_q : '0;
            out_pending_q  <= pending_q;
            out_wait_q     <= wait_q;
            out_dropped_q  <= dropped_q;
            out_last_q     <= 1'b1;
            held_v_q       <= 1'b0;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign released_o   = out_released_q;
  assign out_id_o     = out_id_q;
  assign out_handle_o = out_handle_q;
  assign pending_o    = out_pending_q;
  assign wait_ms_o    = out_wait_q;
  assign dropped_o    = out_dropped_q;
  assign last_o       = out_last_q;

  a_mid_result_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_released_q && !out_pending_q && !out_dropped_q)
    else $error("non-final result without a release");

  a_write_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> started_q)
    else $error("slot written before the first arrival");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o && cmd_i.op == OP_FLUSH |=> slot_full_q == '0 && !started_q)
    else $error("flush left state behind");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walked_q <= WK'(RING_DEPTH))
    else $error("release pass walked past the ring");

  a_drop_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_dropped_q |-> out_last_q && !out_released_q)
    else $error("dropped arrival released a packet");

endmodule

@@ rtl/core/timed_resequencing_playout_buffer_unit.sv @@
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    func, packet_id, packet_handle, times, recovered
// out       output     out_valid_o / out_stall_i  released, out_id, out_handle, status, last
// cfg       input      cfg_we_i                   cfg_wdata_i (playout delay, ms)
//
// an item is taken from a two-entry queue and executed on its own; a new item
// waits until the previous one has put out its last result
// arrival: window check (skipped on the first), due time, slot write, then the pass if it runs
// release pass: a read and a check state per walked slot, with waits on a stalled output
// status: read, check and emit, plus division by 1000 (16 bits a cycle) when a wait is due
// reset clears all slot valid bits at once; no clearing pass; ring depth is a power of two
module timed_resequencing_playout_buffer_unit import trpb_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [DELAY_BITS-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [ID_BITS-1:0]     packet_id_i,
  input  logic [HANDLE_BITS-1:0] packet_handle_i,
  input  logic [TIME_BITS-1:0]   sent_time_us_i,
  input  logic [TIME_BITS-1:0]   now_us_i,
  input  logic                   recovered_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   released_o,
  output logic [ID_BITS-1:0]     out_id_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   pending_o,
  output logic [WAIT_BITS-1:0]   wait_ms_o,
  output logic                   dropped_o,
  output logic                   last_o
);

  logic [DELAY_BITS-1:0]  delay_q;
  logic                   cmd_valid, cmd_pop;
  cmd_t                   cmd;
  logic [ID_BITS-1:0]     cmd_id;
  logic [HANDLE_BITS-1:0] cmd_handle;
  logic [TIME_BITS-1:0]   cmd_sent, cmd_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  trpb_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .packet_id_i,
    .packet_handle_i,
    .sent_time_us_i,
    .now_us_i,
    .recovered_i,
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd),
    .cmd_id_o     (cmd_id),
    .cmd_handle_o (cmd_handle),
    .cmd_sent_o   (cmd_sent),
    .cmd_now_o    (cmd_now)
  );

  trpb_back #(.RING_DEPTH(RING_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .delay_ms_i   (delay_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .cmd_id_i     (cmd_id),
    .cmd_handle_i (cmd_handle),
    .cmd_sent_i   (cmd_sent),
    .cmd_now_i    (cmd_now),
    .out_valid_o,
    .out_stall_i,
    .released_o,
    .out_id_o,
    .out_handle_o,
    .pending_o,
    .wait_ms_o,
    .dropped_o,
    .last_o
  );

endmodule
